// File: rtl/assert_macros.svh
// Assertion macros shared by the quadratic root solver RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define QRS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define QRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/qrs_pkg.sv
// Types and constants for the quadratic root solver.
// Depends on nothing; used by the top level and the bench.
package qrs_pkg;

  localparam int unsigned DiscW = 34;
  localparam int unsigned DmagW = 33;
  localparam int unsigned RootW = 25;
  localparam int unsigned RadW  = 2 * RootW;
  localparam int unsigned NumW  = 34;
  localparam int unsigned DenW  = 16;

  localparam logic [1:0] StatusReal    = 2'd0;
  localparam logic [1:0] StatusComplex = 2'd1;
  localparam logic [1:0] StatusDegen   = 2'd2;

  // Context carried alongside the square root cells.
  typedef struct packed {
    logic signed [DiscW-1:0] disc;
    logic signed [15:0]      a;
    logic signed [15:0]      b;
  } sq_ctx_t;

  // Context carried alongside the first divider.
  typedef struct packed {
    logic [1:0]              status;
    logic signed [DiscW-1:0] disc;
    logic                    neg1;
  } dv_ctx_t;

endpackage

// File: rtl/qrs_sqrt_cell.sv
// One digit cell of the square root chain: one root bit per cell.
// Depends on nothing beyond its parameters.
module qrs_sqrt_cell #(
  parameter int unsigned ROOT_W = 25,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  valid_in,
  input  logic [2*ROOT_W-1:0]   x_in,
  input  logic [ROOT_W+1:0]     rem_in,
  input  logic [ROOT_W-1:0]     root_in,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  valid,
  output logic [2*ROOT_W-1:0]   x,
  output logic [ROOT_W+1:0]     rem,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     side
);

  localparam int unsigned RemW = ROOT_W + 2;

  logic [RemW-1:0] trial;
  logic [RemW-1:0] sub;
  logic [RemW:0]   diff;
  logic            take;

  // Bring down the next two radicand bits and try the next root bit.
  assign trial = {rem_in[RemW-3:0], x_in[2*ROOT_W-1 -: 2]};
  assign sub   = {root_in, 2'b01};
  assign diff  = {1'b0, trial} - {1'b0, sub};
  assign take  = ~diff[RemW];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      x    <= {x_in[2*ROOT_W-3:0], 2'b00};
      rem  <= take ? diff[RemW-1:0] : trial;
      root <= {root_in[ROOT_W-2:0], take};
      side <= side_in;
    end
  end

endmodule

// File: rtl/qrs_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on nothing beyond its parameters.
module qrs_div_cell #(
  parameter int unsigned NUM_W  = 34,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  logic [NUM_W-1:0]   n_in,
  input  logic [DEN_W-1:0]   d_in,
  input  logic [DEN_W-1:0]   rem_in,
  input  logic [NUM_W-1:0]   q_in,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               valid,
  output logic [NUM_W-1:0]   n,
  output logic [DEN_W-1:0]   d,
  output logic [DEN_W-1:0]   rem,
  output logic [NUM_W-1:0]   q,
  output logic [SIDE_W-1:0]  side
);

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           take;

  // Shift in the next dividend bit and subtract the divisor if it fits.
  assign trial = {rem_in, n_in[NUM_W-1]};
  assign diff  = trial - {1'b0, d_in};
  assign take  = trial >= {1'b0, d_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      n    <= {n_in[NUM_W-2:0], 1'b0};
      d    <= d_in;
      rem  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q    <= {q_in[NUM_W-2:0], take};
      side <= side_in;
    end
  end

endmodule

// File: rtl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: multipliers, cell chains, output.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and assert_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall carries coef_a, coef_b, coef_c in
//   signed Q8.8. A transfer happens on a rising edge with in_valid high
//   and in_stall low. Output channel out_valid / out_stall carries status,
//   discriminant (Q18.16), first_value, second_value (Q16.16, saturated)
//   and the saturated flag, one result per input.
//   Throughput is one coefficient set per cycle unless the output stalls.
//   The pipeline holds the multiply stage, the discriminant stage, 25
//   square root cells (one root bit each), one numerator stage, 34 divider
//   cells (one quotient bit each, two dividers side by side) and one output stage.
//   The pipeline moves as one: when a result waits with out_stall high,
//   every stage holds and in_stall rises in the same cycle.
//   A synchronous reset clears every valid bit; no result is in flight
//   afterwards. A zero coef_a gives status 2 with zero roots.
`include "assert_macros.svh"

module quadratic_root_solver_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] coef_a,
  input  logic signed [15:0] coef_b,
  input  logic signed [15:0] coef_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [33:0] discriminant,
  output logic signed [31:0] first_value,
  output logic signed [31:0] second_value,
  output logic               saturated
);

  localparam int unsigned RootW = qrs_pkg::RootW;
  localparam int unsigned RadW  = qrs_pkg::RadW;
  localparam int unsigned NumW  = qrs_pkg::NumW;
  localparam int unsigned DenW  = qrs_pkg::DenW;
  localparam int unsigned SqSW  = $bits(qrs_pkg::sq_ctx_t);
  localparam int unsigned DvSW  = $bits(qrs_pkg::dv_ctx_t);

  logic en;
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // Stage one: the two products.
  logic               m_valid;
  logic signed [31:0] m_bb;
  logic signed [31:0] m_ac;
  logic signed [15:0] m_a;
  logic signed [15:0] m_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid;
    end
    if (en) begin
      m_bb <= coef_b * coef_b;
      m_ac <= coef_a * coef_c;
      m_a  <= coef_a;
      m_b  <= coef_b;
    end
  end

  // Stage two: the discriminant and the square root radicand.
  logic                     d_valid;
  logic signed [33:0]       d_disc;
  logic signed [15:0]       d_a;
  logic signed [15:0]       d_b;
  logic signed [33:0]       disc_next;

  assign disc_next = 34'(m_bb) - (34'(m_ac) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= m_valid;
    end
    if (en) begin
      d_disc <= disc_next;
      d_a    <= m_a;
      d_b    <= m_b;
    end
  end

  logic [qrs_pkg::DmagW-1:0] dmag;
  assign dmag = d_disc[33] ? qrs_pkg::DmagW'(-d_disc) : d_disc[qrs_pkg::DmagW-1:0];

  qrs_pkg::sq_ctx_t sq_ctx0;
  assign sq_ctx0 = '{disc: d_disc, a: d_a, b: d_b};

  // Square root chain, one root bit per cell.
  logic              sq_v   [0:RootW];
  logic [RadW-1:0]   sq_x   [0:RootW];
  logic [RootW+1:0]  sq_rem [0:RootW];
  logic [RootW-1:0]  sq_root[0:RootW];
  logic [SqSW-1:0]   sq_side[0:RootW];

  assign sq_v[0]    = d_valid;
  assign sq_x[0]    = {{(RadW-qrs_pkg::DmagW-16){1'b0}}, dmag, 16'b0};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = sq_ctx0;

  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.ROOT_W(RootW), .SIDE_W(SqSW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(sq_v[i]),
      .x_in    (sq_x[i]),
      .rem_in  (sq_rem[i]),
      .root_in (sq_root[i]),
      .side_in (sq_side[i]),
      .valid   (sq_v[i+1]),
      .x       (sq_x[i+1]),
      .rem     (sq_rem[i+1]),
      .root    (sq_root[i+1]),
      .side    (sq_side[i+1])
    );
  end

  // Numerator stage: pick numerators and signs, add half the divisor.
  qrs_pkg::sq_ctx_t   sq_ctx;
  logic signed [26:0] nb;
  logic signed [26:0] sv;
  logic signed [26:0] num1;
  logic signed [26:0] num2;
  logic [26:0]        mag1;
  logic [26:0]        mag2;
  logic [DenW-1:0]    den;
  logic               cplx;
  logic               a_neg;

  assign sq_ctx = qrs_pkg::sq_ctx_t'(sq_side[RootW]);
  assign nb     = -(27'(sq_ctx.b) <<< 8);
  assign sv     = 27'(sq_root[RootW]);
  assign cplx   = sq_ctx.disc[33];
  assign a_neg  = sq_ctx.a[15];
  assign num1   = cplx ? nb : nb + sv;
  assign num2   = cplx ? sv : nb - sv;
  assign mag1   = num1[26] ? -num1 : num1;
  assign mag2   = num2[26] ? -num2 : num2;
  assign den    = a_neg ? DenW'(-sq_ctx.a) : DenW'(sq_ctx.a);

  logic               p_valid;
  logic [NumW-1:0]    p_n1;
  logic [NumW-1:0]    p_n2;
  logic [DenW-1:0]    p_den;
  qrs_pkg::dv_ctx_t   p_ctx;
  logic               p_neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= sq_v[RootW];
    end
    if (en) begin
      p_n1   <= (NumW'(mag1) << 7) + NumW'(den >> 1);
      p_n2   <= (NumW'(mag2) << 7) + NumW'(den >> 1);
      p_den  <= den;
      p_ctx.disc <= sq_ctx.disc;
      p_ctx.neg1 <= num1[26] ^ a_neg;
      p_neg2     <= num2[26] ^ (a_neg & ~cplx);
      if (sq_ctx.a == 16'sd0) begin
        p_ctx.status <= qrs_pkg::StatusDegen;
      end else if (cplx) begin
        p_ctx.status <= qrs_pkg::StatusComplex;
      end else begin
        p_ctx.status <= qrs_pkg::StatusReal;
      end
    end
  end

  // Two divider chains side by side, one quotient bit per cell.
  logic            dv_v   [0:NumW];
  logic [NumW-1:0] dv_n1  [0:NumW];
  logic [NumW-1:0] dv_n2  [0:NumW];
  logic [DenW-1:0] dv_d1  [0:NumW];
  logic [DenW-1:0] dv_d2  [0:NumW];
  logic [DenW-1:0] dv_r1  [0:NumW];
  logic [DenW-1:0] dv_r2  [0:NumW];
  logic [NumW-1:0] dv_q1  [0:NumW];
  logic [NumW-1:0] dv_q2  [0:NumW];
  logic [DvSW-1:0] dv_s1  [0:NumW];
  logic            dv_s2  [0:NumW];
  logic            dv_v2  [0:NumW];

  assign dv_v[0]  = p_valid;
  assign dv_v2[0] = p_valid;
  assign dv_n1[0] = p_n1;
  assign dv_n2[0] = p_n2;
  assign dv_d1[0] = p_den;
  assign dv_d2[0] = p_den;
  assign dv_r1[0] = '0;
  assign dv_r2[0] = '0;
  assign dv_q1[0] = '0;
  assign dv_q2[0] = '0;
  assign dv_s1[0] = p_ctx;
  assign dv_s2[0] = p_neg2;

  for (genvar i = 0; i < NumW; i++) begin : g_div
    qrs_div_cell #(.NUM_W(NumW), .DEN_W(DenW), .SIDE_W(DvSW)) u_first (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(dv_v[i]),
      .n_in    (dv_n1[i]),
      .d_in    (dv_d1[i]),
      .rem_in  (dv_r1[i]),
      .q_in    (dv_q1[i]),
      .side_in (dv_s1[i]),
      .valid   (dv_v[i+1]),
      .n       (dv_n1[i+1]),
      .d       (dv_d1[i+1]),
      .rem     (dv_r1[i+1]),
      .q       (dv_q1[i+1]),
      .side    (dv_s1[i+1])
    );
    qrs_div_cell #(.NUM_W(NumW), .DEN_W(DenW), .SIDE_W(1)) u_second (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(dv_v2[i]),
      .n_in    (dv_n2[i]),
      .d_in    (dv_d2[i]),
      .rem_in  (dv_r2[i]),
      .q_in    (dv_q2[i]),
      .side_in (dv_s2[i]),
      .valid   (dv_v2[i+1]),
      .n       (dv_n2[i+1]),
      .d       (dv_d2[i+1]),
      .rem     (dv_r2[i+1]),
      .q       (dv_q2[i+1]),
      .side    (dv_s2[i+1])
    );
  end

  // Output stage: apply signs, saturate, force zeros when degenerate.
  qrs_pkg::dv_ctx_t dv_ctx;
  logic [NumW-1:0]  q1;
  logic [NumW-1:0]  q2;
  logic             neg2;
  logic             sat1;
  logic             sat2;
  logic [31:0]      val1;
  logic [31:0]      val2;
  logic             degen;

  assign dv_ctx = qrs_pkg::dv_ctx_t'(dv_s1[NumW]);
  assign q1     = dv_q1[NumW];
  assign q2     = dv_q2[NumW];
  assign neg2   = dv_s2[NumW];
  assign degen  = dv_ctx.status == qrs_pkg::StatusDegen;

  always_comb begin
    if (dv_ctx.neg1) begin
      sat1 = q1 > NumW'(34'h0_8000_0000);
      val1 = sat1 ? 32'h8000_0000 : 32'(-q1);
    end else begin
      sat1 = q1 > NumW'(34'h0_7FFF_FFFF);
      val1 = sat1 ? 32'h7FFF_FFFF : q1[31:0];
    end
    if (neg2) begin
      sat2 = q2 > NumW'(34'h0_8000_0000);
      val2 = sat2 ? 32'h8000_0000 : 32'(-q2);
    end else begin
      sat2 = q2 > NumW'(34'h0_7FFF_FFFF);
      val2 = sat2 ? 32'h7FFF_FFFF : q2[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[NumW];
    end
    if (en) begin
      status       <= dv_ctx.status;
      discriminant <= dv_ctx.disc;
      first_value  <= degen ? 32'sd0 : val1;
      second_value <= degen ? 32'sd0 : val2;
      saturated    <= ~degen & (sat1 | sat2);
    end
  end

  // Checks on the block's own pipeline behavior.
  `QRS_ASSERT(a_degen_zero, clk, rst,
    out_valid && status == qrs_pkg::StatusDegen |-> first_value == 0 && second_value == 0 && !saturated,
    "degenerate result carries nonzero roots")
  `QRS_ASSERT(a_imag_nonneg, clk, rst,
    out_valid && status == qrs_pkg::StatusComplex |-> !second_value[31],
    "imaginary magnitude is negative")
  `QRS_ASSERT(a_status_disc, clk, rst,
    out_valid && status == qrs_pkg::StatusReal |-> !discriminant[33],
    "real roots reported with negative discriminant")
  `QRS_ASSERT(a_hold_out, clk, rst,
    out_valid && out_stall |=> out_valid && $stable(first_value) && $stable(second_value),
    "stalled result changed")

endmodule

// File: bench/quadratic_root_solver_unit_tb.sv
// Self-checking bench for quadratic_root_solver_unit: directed and random
// coefficient sets, bursty sender, stalling receiver. Depends on qrs_pkg.
module quadratic_root_solver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } coef_set_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [33:0] disc;
    logic signed [31:0] first;
    logic signed [31:0] second;
    logic               sat;
  } roots_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] coef_a = 0;
  logic signed [15:0] coef_b = 0;
  logic signed [15:0] coef_c = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         status;
  logic signed [33:0] discriminant;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic               saturated;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  bit        taken = 0;
  int        errors = 0;
  int        accepted_cnt = 0;
  int        checked_cnt = 0;
  int        real_cnt = 0, complex_cnt = 0, degen_cnt = 0, sat_cnt = 0;
  int        cycle_cnt = 0;
  int        gap_left = 0, burst_left = 0;
  int        stall_mode = 0, mode_left = 0, hold_left = 0;
  bit        hold_done = 0;

  quadratic_root_solver_unit DUT (.*);

  always #2 clk = ~clk;

  // Integer square root, truncated downward.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // num*128/den rounded half away from zero; the top bit flags clipping.
  function automatic logic [32:0] scaled_quotient(longint num, longint den);
    longint          p;
    longint unsigned mag, d, q;
    bit              neg;
    p = num * 128;
    mag = (p < 0) ? -p : p;
    d = (den < 0) ? -den : den;
    neg = (p < 0) != (den < 0);
    q = (mag + d / 2) / d;
    if (neg) begin
      if (q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-q)};
    end
    if (q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[31:0]};
  endfunction

  // Expected roots for one coefficient set.
  function automatic roots_t solve_roots(coef_set_t cs);
    roots_t          r;
    longint          a, b, c, disc, s, nb;
    longint unsigned dmag;
    logic [32:0]     q1, q2;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    disc = b * b - 4 * a * c;
    r = '0;
    r.disc = disc[33:0];
    if (a == 0) begin
      r.status = qrs_pkg::StatusDegen;
      return r;
    end
    dmag = (disc < 0) ? -disc : disc;
    s = int_sqrt(dmag << 16);
    nb = -b * 256;
    if (disc >= 0) begin
      r.status = qrs_pkg::StatusReal;
      q1 = scaled_quotient(nb + s, a);
      q2 = scaled_quotient(nb - s, a);
    end else begin
      r.status = qrs_pkg::StatusComplex;
      q1 = scaled_quotient(nb, a);
      q2 = scaled_quotient(s, (a < 0) ? -a : a);
    end
    r.first = q1[31:0];
    r.second = q2[31:0];
    r.sat = q1[32] | q2[32];
    return r;
  endfunction

  function automatic void add_set(int a, int b, int c);
    coef_set_t cs;
    cs.a = 16'(a);
    cs.b = 16'(b);
    cs.c = 16'(c);
    pending_sets.push_back(cs);
  endfunction

  // Record each input transfer and what it should produce.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_roots.push_back(solve_roots({coef_a, coef_b, coef_c}));
      accepted_cnt++;
      taken = 1;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!in_valid || taken)) begin
      taken = 0;
      if (gap_left > 0 || pending_sets.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left--;
      end else begin
        coef_a <= pending_sets[0].a;
        coef_b <= pending_sets[0].b;
        coef_c <= pending_sets[0].c;
        void'(pending_sets.pop_front());
        in_valid <= 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Receiver: changing stall patterns plus one long hold-off to fill the pipe.
  always @(negedge clk) begin
    if (!hold_done && accepted_cnt >= 200) begin
      hold_done = 1;
      hold_left = 300;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    roots_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_roots.pop_front();
        checked_cnt++;
        case (e.status)
          qrs_pkg::StatusReal:    real_cnt++;
          qrs_pkg::StatusComplex: complex_cnt++;
          default:                degen_cnt++;
        endcase
        if (e.sat) sat_cnt++;
        if (status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status);
          errors++;
        end
        if (discriminant !== e.disc) begin
          $error("discriminant: expected %0d, actual %0d", e.disc, discriminant);
          errors++;
        end
        if (first_value !== e.first) begin
          $error("first_value: expected %0d, actual %0d", e.first, first_value);
          errors++;
        end
        if (second_value !== e.second) begin
          $error("second_value: expected %0d, actual %0d", e.second, second_value);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0d, actual %0d", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int sel;
    // Directed: extremes, degenerate, zero discriminant, complex, saturation.
    add_set(0, 0, 0);
    add_set(0, -32768, 32767);
    add_set(0, 32767, -32768);
    add_set(256, 512, 256);
    add_set(-256, 512, -256);
    add_set(256, 0, 256);
    add_set(-256, 0, 256);
    add_set(-256, 256, -1024);
    add_set(256, 0, -1024);
    add_set(1, -32768, 0);
    add_set(1, 32767, 0);
    add_set(-1, -32768, 0);
    add_set(1, 0, -32768);
    add_set(-1, 0, 32767);
    add_set(32767, 32767, 32767);
    add_set(-32768, -32768, -32768);
    add_set(-32768, 32767, 32767);
    add_set(32767, -32768, -32768);
    add_set(-32768, 0, -32768);
    add_set(1, 1, 1);
    add_set(-1, -1, -1);
    add_set(32767, 0, 0);
    // Random: full-range sets mixed with small-leading-coefficient, zero-leading-coefficient and small-range ones.
    repeat (650) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        add_set($urandom, $urandom, $urandom);
      else if (sel < 7)
        add_set($urandom_range(0, 15) - 8, $urandom, $urandom);
      else if (sel < 8)
        add_set(0, $urandom, $urandom);
      else
        add_set($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                $urandom_range(0, 2047) - 1024);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    wait (pending_sets.size() == 0 && !in_valid);
    wait (expected_roots.size() == 0);
    repeat (80) @(posedge clk);
    $display("Checked %0d results: %0d real, %0d complex, %0d degenerate.",
             checked_cnt, real_cnt, complex_cnt, degen_cnt);
    $display("Results with clipped roots: %0d.", sat_cnt);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_unit.sv
bench/quadratic_root_solver_unit_tb.sv
